// File: rtl/lru_key_value_cache_core_defines.svh
// Assertion macros shared by the cache checker.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// Same-cycle implication under clock and active-low reset.
`define LKVC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under clock and active-low reset.
`define LKVC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lkvc_pkg.sv
// Shared constants, opcodes and control types of the LRU key-value cache.
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W      = IDX_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_RESET   = 16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;
    logic exec;
  } lkvc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_get;
  } lkvc_sts_t;

endpackage

// File: rtl/lkvc_intf.sv
// Request, response and configuration channel interfaces of the cache.
interface lkvc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [lkvc_pkg::KEY_W-1:0]    lookup_key;
  logic signed [lkvc_pkg::VAL_W-1:0]    store_value;

  modport source (output valid, opcode, lookup_key, store_value, input ready);
  modport sink   (input valid, opcode, lookup_key, store_value, output ready);
endinterface

interface lkvc_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic signed [lkvc_pkg::VAL_W-1:0]    read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lkvc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic        [lkvc_pkg::CAP_W-1:0]    capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

// File: rtl/lkvc_ctrl.sv
// Controller state machine: request intake, execute step and response valid.
module lkvc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  lkvc_pkg::lkvc_sts_t sts_i,
  output lkvc_pkg::lkvc_cmd_t cmd_o
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       fire;

  // Execute once a put, or once the output register can take the get result.
  assign fire = (state_q == ST_EXEC) &&
                (!sts_i.is_get || !rsp_valid_q || rsp_ready_i);

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o.load_req = 1'b0;
    cmd_o.exec     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Set on a finished get, drop once the response is taken.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (fire && sts_i.is_get) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;

endmodule

// File: rtl/lkvc_datapath.sv
// Datapath: entry store, parallel key compare, recency ranks and result register.
module lkvc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic        [lkvc_pkg::CAP_W-1:0]   cfg_data_i,
  input  logic                                req_op_i,
  input  logic        [lkvc_pkg::KEY_W-1:0]   req_key_i,
  input  logic        [lkvc_pkg::VAL_W-1:0]   req_val_i,
  input  lkvc_pkg::lkvc_cmd_t                 cmd_i,
  output lkvc_pkg::lkvc_sts_t                 sts_o,
  output logic                                rsp_hit_o,
  output logic        [lkvc_pkg::VAL_W-1:0]   rsp_value_o
);

  localparam int N = lkvc_pkg::MAX_ENTRIES;

  logic [lkvc_pkg::CAP_W-1:0]  cap_q;
  logic                        req_op_q;
  logic [lkvc_pkg::KEY_W-1:0]  req_key_q;
  logic [lkvc_pkg::VAL_W-1:0]  req_val_q;
  logic [N-1:0]                valid_q;
  logic [lkvc_pkg::KEY_W-1:0]  key_q  [N];
  logic [lkvc_pkg::VAL_W-1:0]  val_q  [N];
  logic [lkvc_pkg::RANK_W-1:0] rank_q [N];
  logic [lkvc_pkg::CNT_W-1:0]  used_q;
  logic                        rsp_hit_q;
  logic [lkvc_pkg::VAL_W-1:0]  rsp_value_q;

  logic [N-1:0]                match;
  logic                        hit_any;
  logic [lkvc_pkg::IDX_W-1:0]  hit_idx;
  logic [lkvc_pkg::IDX_W-1:0]  free_idx;
  logic [lkvc_pkg::IDX_W-1:0]  oldest_idx;
  logic [lkvc_pkg::IDX_W-1:0]  tgt_idx;
  logic [lkvc_pkg::RANK_W-1:0] oldest_rank;
  logic [lkvc_pkg::CMP_W-1:0]  eff_cap;
  logic [lkvc_pkg::CMP_W-1:0]  cap_ext;
  logic                        fill;
  logic                        is_put;
  logic                        update;
  logic [lkvc_pkg::CNT_W-1:0]  old_rank;

  assign is_put = (req_op_q == lkvc_pkg::OP_PUT);

  // Clamp the capacity to one..MAX_ENTRIES.
  always_comb begin
    cap_ext = lkvc_pkg::CMP_W'(cap_q);
    if (cap_q == '0) begin
      eff_cap = lkvc_pkg::CMP_W'(1);
    end else if (cap_ext > lkvc_pkg::CMP_W'(N)) begin
      eff_cap = lkvc_pkg::CMP_W'(N);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Compare the key against every entry, pick first hit, first free, oldest.
  assign oldest_rank = lkvc_pkg::RANK_W'(used_q - lkvc_pkg::CNT_W'(1));

  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    oldest_idx = '0;
    for (int j = N - 1; j >= 0; j--) begin
      match[j] = valid_q[j] && (key_q[j] == req_key_q);
      if (match[j]) begin
        hit_idx = lkvc_pkg::IDX_W'(j);
      end
      if (!valid_q[j]) begin
        free_idx = lkvc_pkg::IDX_W'(j);
      end
      if (valid_q[j] && (rank_q[j] == oldest_rank)) begin
        oldest_idx = lkvc_pkg::IDX_W'(j);
      end
    end
  end

  assign hit_any = |match;
  assign fill    = !hit_any && (lkvc_pkg::CMP_W'(used_q) < eff_cap);
  assign update  = cmd_i.exec && (hit_any || is_put);

  // Choose the entry to promote and the rank it leaves behind.
  always_comb begin
    if (hit_any) begin
      tgt_idx  = hit_idx;
      old_rank = lkvc_pkg::CNT_W'(rank_q[hit_idx]);
    end else if (fill) begin
      tgt_idx  = free_idx;
      old_rank = used_q;
    end else begin
      tgt_idx  = oldest_idx;
      old_rank = lkvc_pkg::CNT_W'(oldest_rank);
    end
  end

  // Hold the capacity register and the accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RESET);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_op_q  <= req_op_i;
      req_key_q <= req_key_i;
      req_val_q <= req_val_i;
    end
  end

  // Age younger entries, promote the target, count fills.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int j = 0; j < N; j++) begin
        rank_q[j] <= '0;
      end
    end else if (update) begin
      for (int j = 0; j < N; j++) begin
        if (valid_q[j] && (lkvc_pkg::CNT_W'(rank_q[j]) < old_rank)) begin
          rank_q[j] <= lkvc_pkg::RANK_W'(rank_q[j] + 1'b1);
        end
      end
      rank_q[tgt_idx] <= '0;
      if (is_put) begin
        valid_q[tgt_idx] <= 1'b1;
        if (!hit_any && fill) begin
          used_q <= lkvc_pkg::CNT_W'(used_q + 1'b1);
        end
      end
    end
  end

  // Write key and value on a put.
  always_ff @(posedge clk_i) begin
    if (update && is_put) begin
      key_q[tgt_idx] <= req_key_q;
      val_q[tgt_idx] <= req_val_q;
    end
  end

  // Load the get result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !is_put) begin
      rsp_hit_q   <= hit_any;
      rsp_value_q <= hit_any ? val_q[hit_idx] : '0;
    end
  end

  assign sts_o.is_get = (req_op_q == lkvc_pkg::OP_GET);
  assign rsp_hit_o    = rsp_hit_q;
  assign rsp_value_o  = rsp_value_q;

endmodule

// File: rtl/lru_key_value_cache_core.sv
// Each request is loaded at intake, then handled in an execute step doing
// the parallel key compare and recency update, where a get result is
// registered. No new request is taken until execute ends; a get waits in
// execute while a previous result is still held in the output register.
// Reset: asynchronous, active low; empties the cache, clears ranks and count,
// and sets capacity_in_use to 16. Configuration is always ready.
module lru_key_value_cache_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  lkvc_req_if.sink    req,
  lkvc_rsp_if.source  rsp,
  lkvc_cfg_if.sink    cfg
);

  lkvc_pkg::lkvc_cmd_t cmd;
  lkvc_pkg::lkvc_sts_t sts;
  logic                rsp_hit;
  logic [lkvc_pkg::VAL_W-1:0] rsp_value;

  assign cfg.ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lkvc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg.valid),
    .cfg_data_i  (cfg.capacity_in_use),
    .req_op_i    (req.opcode),
    .req_key_i   (req.lookup_key),
    .req_val_i   (req.store_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_hit_o   (rsp_hit),
    .rsp_value_o (rsp_value)
  );

  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;

endmodule

// File: rtl/lkvc_checker.sv
// Port-level checker for the cache core and its bind.
`include "lru_key_value_cache_core_defines.svh"

module lkvc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        req_opcode_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        rsp_hit_i,
  input logic [lkvc_pkg::VAL_W-1:0]  rsp_read_value_i
);

  logic req_acc;

  assign req_acc = req_valid_i && req_ready_i;

  // One request at a time: intake closes right after an accept.
  `LKVC_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_acc, !req_ready_i, "intake not closed")

  // A new response appears only after an accepted get has passed through intake and execute.
  `LKVC_ASSERT_NOW(a_rsp_from_get, clk_i, rst_ni, $rose(rsp_valid_i), $past(req_acc && (req_opcode_i == lkvc_pkg::OP_GET), 2), "response without get")

  // A put leaves an empty output empty.
  `LKVC_ASSERT_NEXT(a_put_silent, clk_i, rst_ni, req_acc && (req_opcode_i == lkvc_pkg::OP_PUT) && !rsp_valid_i, !rsp_valid_i ##1 !rsp_valid_i, "put produced a response")

  // A miss carries a zero value.
  `LKVC_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, rsp_valid_i && !rsp_hit_i, rsp_read_value_i == '0, "miss value not zero")

  // A stalled response holds.
  `LKVC_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_hit_i) && $stable(rsp_read_value_i), "stalled response changed")

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req.valid),
  .req_ready_i      (req.ready),
  .req_opcode_i     (req.opcode),
  .rsp_valid_i      (rsp.valid),
  .rsp_ready_i      (rsp.ready),
  .rsp_hit_i        (rsp.hit),
  .rsp_read_value_i (rsp.read_value)
);

// File: test/lru_key_value_cache_core_tb.sv
// Self-checking testbench for the LRU key-value cache core.
module lru_key_value_cache_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 50;
  localparam int KEY_POOL_SIZE = 40;
  localparam int CHOKE_CYCLES  = 400;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic                           op;
    logic [lkvc_pkg::KEY_W-1:0]     key;
    logic [lkvc_pkg::VAL_W-1:0]     value;
    logic                           fixed;
    logic                           hit;
    logic [lkvc_pkg::VAL_W-1:0]     read_value;
    logic [lkvc_pkg::CAP_W-1:0]     cap;
  } stim_row_t;

  typedef struct packed {
    logic                           hit;
    logic [lkvc_pkg::VAL_W-1:0]     value;
  } read_result_t;

  // Directed requests and capacity writes; a set fixed bit marks a result known without the predictor.
  localparam stim_row_t DIRECTED_ROWS [23] = '{
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h8000_0000, 32'hAAAA_5555, 1'b1, 1'b1, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h7FFF_FFFE, 32'h5555_AAAA, 1'b1, 1'b0, 32'h0000_0000, 5'd0},
    // lower the capacity below the count in use
    '{ROW_CFG, lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd2},
    '{ROW_REQ, lkvc_pkg::OP_PUT, 32'h0000_0005, 32'h0000_0055, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    // capacity zero behaves as one
    '{ROW_CFG, lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_PUT, 32'h0000_0006, 32'h0000_0066, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h0000_0006, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    // capacity above the table size saturates
    '{ROW_CFG, lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd31},
    '{ROW_REQ, lkvc_pkg::OP_PUT, 32'h0000_0007, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
    '{ROW_REQ, lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0}
  };

  localparam logic [lkvc_pkg::CAP_W-1:0] PHASE_CAPS [8] = '{
    5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd8, 5'd12, 5'd16
  };

  logic clk_i;
  logic rst_ni;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();
  lkvc_cfg_if cfg_ch ();

  lru_key_value_cache_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch)
  );

  // Shadow copy of the cache contents and recency order
  logic                         mirror_valid [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::KEY_W-1:0]   mirror_key   [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0]   mirror_value [lkvc_pkg::MAX_ENTRIES];
  int unsigned                  mirror_rank  [lkvc_pkg::MAX_ENTRIES];
  int unsigned                  mirror_used;
  logic [lkvc_pkg::CAP_W-1:0]   mirror_cap;

  read_result_t                 pending_reads [$];
  logic [lkvc_pkg::KEY_W-1:0]   key_pool [KEY_POOL_SIZE];
  int unsigned                  fail_count;
  int unsigned                  cycle_count;
  bit                           calm;
  bit                           choke_rsp;

  function automatic int unsigned effective_cap(input logic [lkvc_pkg::CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > lkvc_pkg::MAX_ENTRIES) return lkvc_pkg::MAX_ENTRIES;
    return cap;
  endfunction

  // Move one valid entry to the front of the recency order.
  function automatic void promote_entry(input int slot);
    int unsigned old_rank;
    old_rank = mirror_rank[slot];
    for (int j = 0; j < lkvc_pkg::MAX_ENTRIES; j++) begin
      if (mirror_valid[j] && mirror_rank[j] < old_rank) mirror_rank[j]++;
    end
    mirror_rank[slot] = 0;
  endfunction

  // Apply one request to the shadow cache; return 1 when it yields a read result.
  function automatic bit predict_access(input logic op, input logic [lkvc_pkg::KEY_W-1:0] k,
                                        input logic [lkvc_pkg::VAL_W-1:0] v,
                                        output read_result_t res);
    int slot;
    int free_slot;
    int oldest;
    int unsigned oldest_rank;
    slot      = -1;
    free_slot = -1;
    oldest    = -1;
    oldest_rank = 0;
    res = '0;
    for (int j = 0; j < lkvc_pkg::MAX_ENTRIES; j++) begin
      if (slot < 0 && mirror_valid[j] && mirror_key[j] == k) slot = j;
      if (free_slot < 0 && !mirror_valid[j]) free_slot = j;
      if (mirror_valid[j] && (oldest < 0 || mirror_rank[j] > oldest_rank)) begin
        oldest      = j;
        oldest_rank = mirror_rank[j];
      end
    end

    if (op == lkvc_pkg::OP_GET) begin
      if (slot >= 0) begin
        res.hit   = 1'b1;
        res.value = mirror_value[slot];
        promote_entry(slot);
      end
      return 1'b1;
    end

    if (slot >= 0) begin
      mirror_value[slot] = v;
      promote_entry(slot);
    end else if (mirror_used < effective_cap(mirror_cap) && free_slot >= 0) begin
      // Fill a free entry and age everything else
      for (int j = 0; j < lkvc_pkg::MAX_ENTRIES; j++) begin
        if (mirror_valid[j]) mirror_rank[j]++;
      end
      mirror_valid[free_slot] = 1'b1;
      mirror_key[free_slot]   = k;
      mirror_value[free_slot] = v;
      mirror_rank[free_slot]  = 0;
      mirror_used++;
    end else if (oldest >= 0) begin
      // Replace the least recent entry; the count stays put
      mirror_key[oldest]   = k;
      mirror_value[oldest] = v;
      promote_entry(oldest);
    end
    return 1'b0;
  endfunction

  // Offer one request, with an optional idle burst ahead of it.
  task automatic send_request(input logic op, input logic [lkvc_pkg::KEY_W-1:0] k,
                              input logic [lkvc_pkg::VAL_W-1:0] v, input bit fixed,
                              input read_result_t fixed_res);
    read_result_t res;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.lookup_key  <= k;
    req_ch.store_value <= v;
    do @(posedge clk_i); while (!req_ch.ready);
    if (predict_access(op, k, v, res)) pending_reads.push_back(fixed ? fixed_res : res);
  endtask

  // Drain the block, then write the capacity register.
  task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
    req_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.capacity_in_use <= cap;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    mirror_cap = cap;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hold off the result side in random bursts, once for a long stretch
  initial begin
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (choke_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk_i);
        choke_rsp = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result with the oldest pending read
  always @(posedge clk_i) begin
    read_result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_reads.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: hit=%0b value=%h", rsp_ch.hit, rsp_ch.read_value);
      end else begin
        want = pending_reads.pop_front();
        if (rsp_ch.hit !== want.hit || rsp_ch.read_value !== want.value) begin
          fail_count++;
          if (fail_count <= 10)
            $display("read mismatch: expected hit=%0b value=%h, got hit=%0b value=%h",
                     want.hit, want.value, rsp_ch.hit, rsp_ch.read_value);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    read_result_t                 fixed_res;
    logic [lkvc_pkg::CAP_W-1:0]   cap;
    logic [lkvc_pkg::KEY_W-1:0]   k;
    logic [lkvc_pkg::VAL_W-1:0]   v;
    logic                         op;
    int unsigned                  pool_n;
    int unsigned                  pool_base;

    fail_count = 0;
    calm       = 1'b0;
    choke_rsp  = 1'b0;
    mirror_used = 0;
    mirror_cap  = lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RESET);
    for (int j = 0; j < lkvc_pkg::MAX_ENTRIES; j++) begin
      mirror_valid[j] = 1'b0;
      mirror_key[j]   = '0;
      mirror_value[j] = '0;
      mirror_rank[j]  = 0;
    end
    // Key pool: extremes first, random keys after
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'h0000_0000;
    key_pool[4] = 32'h0000_0001;
    for (int j = 5; j < KEY_POOL_SIZE; j++) key_pool[j] = $urandom;

    rst_ni                 <= 1'b0;
    req_ch.valid           <= 1'b0;
    req_ch.opcode          <= lkvc_pkg::OP_GET;
    req_ch.lookup_key      <= '0;
    req_ch.store_value     <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.capacity_in_use <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        write_capacity(DIRECTED_ROWS[i].cap);
      end else begin
        fixed_res.hit   = DIRECTED_ROWS[i].hit;
        fixed_res.value = DIRECTED_ROWS[i].read_value;
        send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].value,
                     DIRECTED_ROWS[i].fixed, fixed_res);
      end
    end

    // Random phases, one capacity setting each
    fixed_res = '0;
    for (int ph = 0; ph < 8; ph++) begin
      cap = (ph == 6) ? lkvc_pkg::CAP_W'($urandom_range(2, 15)) : PHASE_CAPS[ph];
      write_capacity(cap);
      if (ph == 1) choke_rsp = 1'b1;
      if (ph == 7) calm = 1'b1;
      // Keep the key set near the capacity so hits and evictions both occur
      pool_n    = effective_cap(cap) + $urandom_range(1, 6);
      pool_base = $urandom_range(0, KEY_POOL_SIZE - 1);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 8) k = $urandom;
        else k = key_pool[(pool_base + $urandom_range(0, pool_n - 1)) % KEY_POOL_SIZE];
        op = ($urandom_range(0, 99) < 45) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
        case ($urandom_range(0, 11))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h0000_0000;
          default: v = $urandom;
        endcase
        send_request(op, k, v, 1'b0, fixed_res);
      end
    end

    // Drain and let the last request settle
    req_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: lru_key_value_cache_core.f
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_intf.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache_core.sv
rtl/lkvc_checker.sv
test/lru_key_value_cache_core_tb.sv
